// ----- rtl/ssi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the SSI bit-bang reader: register layout,
// reset values and the structs that pass between the front, back and
// register block.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int STARTUP_W = 20;
    localparam int GAP_W     = 7;
    localparam int GAPCNT_W  = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [STARTUP_W-1:0] RST_STARTUP_TICKS = 20'd200000;
    localparam logic [GAP_W-1:0]     RST_GAP_LIMIT     = 7'd60;

    // register index, taken from paddr[2]
    localparam logic REG_STARTUP_TICKS = 1'b0;
    localparam logic REG_GAP_LIMIT     = 1'b1;

    typedef struct packed {
        logic [STARTUP_W-1:0] startup_ticks;
        logic [GAP_W-1:0]     gap_limit;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic data;
    } t_qhead;

endpackage

// ----- rtl/ssi_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_cfg
// APB register block: start-up delay and idle gap limit, write and read.
// ----------------------------------------------------------------------------
module ssi_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssi_pkg::APB_AW-1:0]   paddr,
    input  logic [ssi_pkg::APB_DW-1:0]   pwdata,
    output logic [ssi_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output ssi_pkg::t_cfg                o_cfg
);

    ssi_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_ticks <= ssi_pkg::RST_STARTUP_TICKS;
            r_cfg.gap_limit     <= ssi_pkg::RST_GAP_LIMIT;
        end else if (wr_en) begin
            unique case (paddr[2])
                ssi_pkg::REG_STARTUP_TICKS: begin
                    r_cfg.startup_ticks <= pwdata[ssi_pkg::STARTUP_W-1:0];
                end
                ssi_pkg::REG_GAP_LIMIT: begin
                    r_cfg.gap_limit <= pwdata[ssi_pkg::GAP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            ssi_pkg::REG_STARTUP_TICKS: begin
                prdata[ssi_pkg::STARTUP_W-1:0] = r_cfg.startup_ticks;
            end
            ssi_pkg::REG_GAP_LIMIT: begin
                prdata[ssi_pkg::GAP_W-1:0] = r_cfg.gap_limit;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/ssi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_front
// Tick intake: accepts sampled data line transactions into a two-entry queue
// that decouples the intake from the frame sequencer.
// ----------------------------------------------------------------------------
module ssi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_data_in,
    output ssi_pkg::t_qhead o_head,
    input  logic            i_pop
);

    logic       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign o_stall = (r_count == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_data_in;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.data  = r_slot[r_rd_ptr];

endmodule

// ----- rtl/ssi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_back
// Frame sequencer: start-up wait, clock phases, MSB-first sampling, idle gap
// and word latch, with a registered result stage toward the consumer.
// ----------------------------------------------------------------------------
module ssi_back #(
    parameter int WORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssi_pkg::t_cfg        i_cfg,
    input  ssi_pkg::t_qhead      i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_clock_out,
    output logic [WORD_BITS-1:0] o_word_out,
    output logic                 o_word_new
);

    localparam int PW = $clog2(2 * WORD_BITS + 2);
    localparam logic [PW-1:0] FINAL_PHASE = PW'(2 * WORD_BITS + 1);

    logic [ssi_pkg::STARTUP_W-1:0] r_startup_count;
    logic [ssi_pkg::STARTUP_W-1:0] n_startup_count;
    logic [PW-1:0]                 r_phase;
    logic [PW-1:0]                 n_phase;
    logic [ssi_pkg::GAPCNT_W-1:0]  r_gap_count;
    logic [ssi_pkg::GAPCNT_W-1:0]  n_gap_count;
    logic [WORD_BITS-1:0]          r_shift;
    logic [WORD_BITS-1:0]          n_shift;
    logic [WORD_BITS-1:0]          r_held;
    logic [WORD_BITS-1:0]          n_held;
    logic                          r_clk_level;
    logic                          n_clk_level;
    logic                          n_fresh;
    logic [PW-2:0]                 half;

    logic                          r_valid;
    logic                          r_clock_out;
    logic [WORD_BITS-1:0]          r_word_out;
    logic                          r_word_new;

    assign o_pop = i_head.valid && (!r_valid || !i_stall);
    assign half  = r_phase[PW-1:1];

    always_comb begin
        n_startup_count = r_startup_count;
        n_phase         = r_phase;
        n_gap_count     = r_gap_count;
        n_shift         = r_shift;
        n_held          = r_held;
        n_clk_level     = r_clk_level;
        n_fresh         = 1'b0;
        if (r_startup_count < i_cfg.startup_ticks) begin
            n_startup_count = r_startup_count + 1'b1;
        end else if (r_phase == '0) begin
            n_clk_level = 1'b0;
            n_shift     = '0;
            n_phase     = PW'(1);
        end else if (r_phase == PW'(1)) begin
            n_clk_level = 1'b1;
            n_phase     = PW'(2);
        end else if (r_phase >= FINAL_PHASE) begin
            n_clk_level = 1'b1;
            n_gap_count = r_gap_count + 1'b1;
            if (r_gap_count > {1'b0, i_cfg.gap_limit}) begin
                n_held      = r_shift;
                n_gap_count = '0;
                n_phase     = '0;
                n_fresh     = 1'b1;
            end
        end else if (!r_phase[0]) begin
            for (int k = 0; k < WORD_BITS; k++) begin
                if (k == WORD_BITS - int'(half)) begin
                    n_shift[k] = i_head.data;
                end
            end
            n_clk_level = 1'b0;
            n_phase     = r_phase + 1'b1;
        end else begin
            n_clk_level = 1'b1;
            n_phase     = r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_count <= '0;
            r_phase         <= '0;
            r_gap_count     <= '0;
            r_shift         <= '0;
            r_held          <= '0;
            r_clk_level     <= 1'b1;
        end else if (o_pop) begin
            r_startup_count <= n_startup_count;
            r_phase         <= n_phase;
            r_gap_count     <= n_gap_count;
            r_shift         <= n_shift;
            r_held          <= n_held;
            r_clk_level     <= n_clk_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_clock_out <= 1'b1;
            r_word_out  <= '0;
            r_word_new  <= 1'b0;
        end else if (o_pop) begin
            r_valid     <= 1'b1;
            r_clock_out <= n_clk_level;
            r_word_out  <= n_held;
            r_word_new  <= n_fresh;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_clock_out = r_clock_out;
    assign o_word_out  = r_word_out;
    assign o_word_new  = r_word_new;

endmodule

// ----- rtl/ssi_bitbang_reader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_bitbang_reader
// Path: accepted ticks pass the intake queue, then the result register.
// Throughput: one tick per cycle when not stalled; the two-entry intake queue
// and the result register let intake and sequencer stall independently.
// Reset: synchronous, active low; clock line idles high, counters and word
// clear, registers return to 200000 start-up ticks and a gap limit of 60.
// ----------------------------------------------------------------------------
module ssi_bitbang_reader #(
    parameter int WORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_data_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_clock_out,
    output logic [WORD_BITS-1:0]         o_word_out,
    output logic                         o_word_new,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssi_pkg::APB_AW-1:0]   paddr,
    input  logic [ssi_pkg::APB_DW-1:0]   pwdata,
    output logic [ssi_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    ssi_pkg::t_cfg   cfg;
    ssi_pkg::t_qhead head;
    logic            pop;

    ssi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data_in (i_data_in),
        .o_head    (head),
        .i_pop     (pop)
    );

    ssi_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_clock_out (o_clock_out),
        .o_word_out  (o_word_out),
        .o_word_new  (o_word_new)
    );

endmodule

// ----- rtl/ssi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks of the SSI bit-bang reader, bound to the top level.
// ----------------------------------------------------------------------------
module ssi_checker #(
    parameter int WORD_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_clock_out,
    input logic [WORD_BITS-1:0] o_word_out,
    input logic                 o_word_new
);

    a_latch_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word_new |-> o_clock_out)
        else $error("word latched while clock driven low");

    a_word_changes_on_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$stable(o_word_out) |-> o_word_new)
        else $error("received word changed without a latch");

    a_stall_needs_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("intake stalled without result backpressure");

    a_hold_stalled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word_out) && $stable(o_clock_out))
        else $error("stalled result transaction changed");

endmodule

bind ssi_bitbang_reader ssi_checker #(
    .WORD_BITS (WORD_BITS)
) u_ssi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_clock_out (o_clock_out),
    .o_word_out  (o_word_out),
    .o_word_new  (o_word_new)
);
